/* hw/rtl/twc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text window console package
// Shared widths, codes, reset values and record types of the console.
// ----------------------------------------------------------------------------
package twc_pkg;

    // Default screen size
    localparam int ROWS_DEF = 25;
    localparam int COLS_DEF = 80;

    // Field widths
    localparam int CMD_W  = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;

    // Width of window bound arithmetic (sums of two register fields)
    localparam int BND_W = 8;

    // Depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Register port
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = 3;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    // Register reset values
    localparam logic [ROW_W-1:0]  TOP_RST    = 5'd0;
    localparam logic [ROW_W-1:0]  HEIGHT_RST = 5'd25;
    localparam logic [COL_W-1:0]  LEFT_RST   = 7'd0;
    localparam logic [COL_W-1:0]  WIDTH_RST  = 7'd80;
    localparam logic [ATTR_W-1:0] ATTR_RST   = 8'd7;

    // Host commands
    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    // Classified operations handed to the back end
    typedef enum logic [2:0] {
        OP_PUT     = 3'd0,
        OP_NEWLINE = 3'd1,
        OP_CLEAR   = 3'd2,
        OP_READ    = 3'd3,
        OP_NOP     = 3'd4
    } t_op;

    // Register indexes
    typedef enum logic [REG_IDX_W-1:0] {
        REG_WIN_TOP    = 3'd0,
        REG_WIN_HEIGHT = 3'd1,
        REG_WIN_LEFT   = 3'd2,
        REG_WIN_WIDTH  = 3'd3,
        REG_TEXT_ATTR  = 3'd4
    } t_reg_idx;

    // Queue entry
    typedef struct packed {
        t_op               op;
        logic [CHAR_W-1:0] ch;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              in_range;
    } t_cmd_rec;

    // Window configuration
    typedef struct packed {
        logic [ROW_W-1:0]  win_top;
        logic [ROW_W-1:0]  win_height;
        logic [COL_W-1:0]  win_left;
        logic [COL_W-1:0]  win_width;
        logic [ATTR_W-1:0] text_attr;
    } t_win_cfg;

endpackage

/* hw/rtl/twc_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text window console channels
// Command channel and result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface twc_in_if;
    import twc_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;

    modport source (output valid, cmd, char_code, read_row, read_col, input ready);
    modport sink   (input valid, cmd, char_code, read_row, read_col, output ready);
endinterface

interface twc_out_if;
    import twc_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;

    modport source (output valid, cell_char, cell_attr, cursor_row, cursor_col,
                    input ready);
    modport sink   (input valid, cell_char, cell_attr, cursor_row, cursor_col,
                    output ready);
endinterface

/* hw/rtl/twc_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text window console registers
// APB-style register file holding the window geometry and text attribute.
// ----------------------------------------------------------------------------
module twc_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [twc_pkg::APB_AW-1:0]  paddr,
    input  logic [twc_pkg::APB_DW-1:0]  pwdata,
    output logic [twc_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output twc_pkg::t_win_cfg           o_cfg
);
    import twc_pkg::*;

    t_win_cfg r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[APB_AW-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    // Write registers on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.win_top    <= TOP_RST;
            r_cfg.win_height <= HEIGHT_RST;
            r_cfg.win_left   <= LEFT_RST;
            r_cfg.win_width  <= WIDTH_RST;
            r_cfg.text_attr  <= ATTR_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_WIN_TOP:    r_cfg.win_top    <= pwdata[ROW_W-1:0];
                REG_WIN_HEIGHT: r_cfg.win_height <= pwdata[ROW_W-1:0];
                REG_WIN_LEFT:   r_cfg.win_left   <= pwdata[COL_W-1:0];
                REG_WIN_WIDTH:  r_cfg.win_width  <= pwdata[COL_W-1:0];
                REG_TEXT_ATTR:  r_cfg.text_attr  <= pwdata[ATTR_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_WIN_TOP:    prdata = APB_DW'(r_cfg.win_top);
            REG_WIN_HEIGHT: prdata = APB_DW'(r_cfg.win_height);
            REG_WIN_LEFT:   prdata = APB_DW'(r_cfg.win_left);
            REG_WIN_WIDTH:  prdata = APB_DW'(r_cfg.win_width);
            REG_TEXT_ATTR:  prdata = APB_DW'(r_cfg.text_attr);
            default:        prdata = '0;
        endcase
    end

endmodule

/* hw/rtl/twc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text window console front end
// Accepts host commands and classifies them into queue entries.
// ----------------------------------------------------------------------------
module twc_front #(
    parameter int ROWS = twc_pkg::ROWS_DEF,
    parameter int COLS = twc_pkg::COLS_DEF
) (
    input  logic              i_init_done,
    twc_in_if.sink            i_in,
    input  logic              i_q_full,
    output logic              o_push,
    output twc_pkg::t_cmd_rec o_rec
);
    import twc_pkg::*;

    // Take a transaction whenever the queue has room and memory is cleared
    assign i_in.ready = i_init_done && !i_q_full;
    assign o_push     = i_in.valid && i_in.ready;

    // Classify the command
    always_comb begin
        o_rec.ch       = i_in.char_code;
        o_rec.row      = i_in.read_row;
        o_rec.col      = i_in.read_col;
        o_rec.in_range = (32'(i_in.read_row) < ROWS) && (32'(i_in.read_col) < COLS);
        unique case (t_cmd'(i_in.cmd))
            CMD_PUT: begin
                if (i_in.char_code == CHAR_LF || i_in.char_code == CHAR_CR) begin
                    o_rec.op = OP_NEWLINE;
                end else begin
                    o_rec.op = OP_PUT;
                end
            end
            CMD_CLEAR: o_rec.op = OP_CLEAR;
            CMD_READ:  o_rec.op = OP_READ;
            CMD_NOP:   o_rec.op = OP_NOP;
        endcase
    end

endmodule

/* hw/rtl/twc_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text window console command queue
// Short FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module twc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  twc_pkg::t_cmd_rec i_rec,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_pop,
    output twc_pkg::t_cmd_rec o_rec
);
    import twc_pkg::*;

    localparam int PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd_rec           r_slot [QUEUE_DEPTH];
    logic [PW-1:0]      r_wr;
    logic [PW-1:0]      r_rd;
    logic [CNT_W-1:0]   r_cnt;
    logic [PW-1:0]      n_wr;
    logic [PW-1:0]      n_rd;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rec   = r_slot[r_rd];

    // Wrap pointers at the queue depth
    always_comb begin
        n_wr = (r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        n_rd = (r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_rec;
        end
    end

endmodule

/* hw/rtl/twc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text window console back end
// Owns the screen memory and cursor; runs puts, newlines, scrolls, clears
// and reads, and drives the registered result channel.
// ----------------------------------------------------------------------------
module twc_back #(
    parameter int ROWS = twc_pkg::ROWS_DEF,
    parameter int COLS = twc_pkg::COLS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  twc_pkg::t_win_cfg i_cfg,
    input  logic              i_q_valid,
    input  twc_pkg::t_cmd_rec i_q_rec,
    output logic              o_pop,
    output logic              o_init_done,
    twc_out_if.source         o_out
);
    import twc_pkg::*;

    localparam int RW     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW     = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int DEPTH  = ROWS * COLS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CELL_W = ATTR_W + CHAR_W;

    typedef enum logic [5:0] {
        S_INIT   = 6'b000001,
        S_IDLE   = 6'b000010,
        S_SCR_RD = 6'b000100,
        S_SCR_WR = 6'b001000,
        S_BLANK  = 6'b010000,
        S_RESP   = 6'b100000
    } t_state;

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                                input logic [CW-1:0] col);
        cell_addr = AW'(row) * AW'(COLS) + AW'(col);
    endfunction

    // Control and payload registers
    t_state             r_state, n_state;
    logic [RW-1:0]      r_cur_y, n_cur_y;
    logic [CW-1:0]      r_cur_x, n_cur_x;
    logic [RW-1:0]      r_row, n_row;
    logic [CW-1:0]      r_col, n_col;
    logic [RW-1:0]      r_end, n_end;
    logic [AW-1:0]      r_init_addr, n_init_addr;
    logic               r_rd_sel, n_rd_sel;
    logic [CELL_W-1:0]  r_rdata;
    logic               r_ovld;
    logic [CHAR_W-1:0]  r_o_char;
    logic [ATTR_W-1:0]  r_o_attr;
    logic [ROW_W-1:0]   r_o_row;
    logic [COL_W-1:0]   r_o_col;

    logic [CELL_W-1:0]  r_mem [DEPTH];

    // Memory port and control strobes
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [CELL_W-1:0]  mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic               load_out;
    logic               do_nl;
    logic               col_more;

    // Window bounds
    logic [BND_W-1:0]   b_top, b_h, b_bot, b_left, b_w, b_right;
    logic [RW-1:0]      w_top, w_bot_m1;
    logic [CW-1:0]      w_left;

    // Clamp the window to the screen
    always_comb begin
        b_top   = (BND_W'(i_cfg.win_top) > BND_W'(ROWS - 1)) ?
                  BND_W'(ROWS - 1) : BND_W'(i_cfg.win_top);
        b_left  = (BND_W'(i_cfg.win_left) > BND_W'(COLS - 1)) ?
                  BND_W'(COLS - 1) : BND_W'(i_cfg.win_left);
        b_h     = (i_cfg.win_height == '0) ? BND_W'(1) : BND_W'(i_cfg.win_height);
        b_w     = (i_cfg.win_width == '0) ? BND_W'(1) : BND_W'(i_cfg.win_width);
        b_bot   = (b_top + b_h > BND_W'(ROWS)) ? BND_W'(ROWS) : b_top + b_h;
        b_right = (b_left + b_w > BND_W'(COLS)) ? BND_W'(COLS) : b_left + b_w;
        w_top    = RW'(b_top);
        w_left   = CW'(b_left);
        w_bot_m1 = RW'(b_bot - BND_W'(1));
    end

    assign col_more    = (BND_W'(r_col) + BND_W'(1)) < b_right;
    assign o_init_done = (r_state != S_INIT);

    // Sequence the operations
    always_comb begin
        n_state     = r_state;
        n_cur_y     = r_cur_y;
        n_cur_x     = r_cur_x;
        n_row       = r_row;
        n_col       = r_col;
        n_end       = r_end;
        n_init_addr = r_init_addr;
        n_rd_sel    = r_rd_sel;
        mem_we      = 1'b0;
        mem_waddr   = cell_addr(r_row, r_col);
        mem_wdata   = {i_cfg.text_attr, CHAR_SPACE};
        mem_re      = 1'b0;
        mem_raddr   = cell_addr(RW'(r_row + 1'b1), r_col);
        o_pop       = 1'b0;
        load_out    = 1'b0;
        do_nl       = 1'b0;

        unique case (r_state)
            S_INIT: begin
                // Zero the screen one cell per cycle
                mem_we    = 1'b1;
                mem_waddr = r_init_addr;
                mem_wdata = '0;
                if (r_init_addr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_init_addr = r_init_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    o_pop    = 1'b1;
                    n_rd_sel = 1'b0;
                    n_state  = S_RESP;
                    unique case (i_q_rec.op)
                        OP_PUT: begin
                            mem_we    = 1'b1;
                            mem_waddr = cell_addr(r_cur_y, r_cur_x);
                            mem_wdata = {i_cfg.text_attr, i_q_rec.ch};
                            if ((BND_W'(r_cur_x) + BND_W'(1)) < b_right) begin
                                n_cur_x = r_cur_x + 1'b1;
                            end else begin
                                do_nl = 1'b1;
                            end
                        end
                        OP_NEWLINE: do_nl = 1'b1;
                        OP_CLEAR: begin
                            n_row   = w_top;
                            n_col   = w_left;
                            n_end   = w_bot_m1;
                            n_cur_y = w_top;
                            n_cur_x = w_left;
                            n_state = S_BLANK;
                        end
                        OP_READ: begin
                            if (i_q_rec.in_range) begin
                                mem_re    = 1'b1;
                                mem_raddr = cell_addr(RW'(i_q_rec.row), CW'(i_q_rec.col));
                                n_rd_sel  = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                    // Newline: move down, or scroll at the window bottom
                    if (do_nl) begin
                        n_cur_x = w_left;
                        if ((BND_W'(r_cur_y) + BND_W'(1)) >= b_bot) begin
                            n_cur_y = w_bot_m1;
                            n_col   = w_left;
                            n_end   = w_bot_m1;
                            if (w_top < w_bot_m1) begin
                                n_row   = w_top;
                                n_state = S_SCR_RD;
                            end else begin
                                n_row   = w_bot_m1;
                                n_state = S_BLANK;
                            end
                        end else begin
                            n_cur_y = r_cur_y + 1'b1;
                        end
                    end
                end
            end
            S_SCR_RD: begin
                // Fetch the cell one row below
                mem_re  = 1'b1;
                n_state = S_SCR_WR;
            end
            S_SCR_WR: begin
                // Copy it up
                mem_we    = 1'b1;
                mem_wdata = r_rdata;
                n_state   = S_SCR_RD;
                if (col_more) begin
                    n_col = r_col + 1'b1;
                end else begin
                    n_col = w_left;
                    if (({1'b0, r_row} + 1'b1) < {1'b0, r_end}) begin
                        n_row = r_row + 1'b1;
                    end else begin
                        n_row   = r_end;
                        n_state = S_BLANK;
                    end
                end
            end
            S_BLANK: begin
                // Fill rows up to the end row with spaces
                mem_we = 1'b1;
                if (col_more) begin
                    n_col = r_col + 1'b1;
                end else begin
                    n_col = w_left;
                    if (r_row < r_end) begin
                        n_row = r_row + 1'b1;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_RESP: begin
                // Hand the result to the output register once it is free
                if (!r_ovld || o_out.ready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Update control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cur_y     <= '0;
            r_cur_x     <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_end       <= '0;
            r_init_addr <= '0;
            r_rd_sel    <= 1'b0;
            r_ovld      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur_y     <= n_cur_y;
            r_cur_x     <= n_cur_x;
            r_row       <= n_row;
            r_col       <= n_col;
            r_end       <= n_end;
            r_init_addr <= n_init_addr;
            r_rd_sel    <= n_rd_sel;
            if (load_out) begin
                r_ovld <= 1'b1;
            end else if (o_out.ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // Screen memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_char <= r_rd_sel ? r_rdata[CHAR_W-1:0] : '0;
            r_o_attr <= r_rd_sel ? r_rdata[CELL_W-1:CHAR_W] : '0;
            r_o_row  <= ROW_W'(r_cur_y);
            r_o_col  <= COL_W'(r_cur_x);
        end
    end

    assign o_out.valid      = r_ovld;
    assign o_out.cell_char  = r_o_char;
    assign o_out.cell_attr  = r_o_attr;
    assign o_out.cursor_row = r_o_row;
    assign o_out.cursor_col = r_o_col;

endmodule

/* hw/rtl/text_window_console.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text window console
// Character-cell screen with a clipped output window, cursor and scrolling.
// ----------------------------------------------------------------------------
// After reset the screen memory is zeroed one cell per cycle; no command is
// taken meanwhile, while register writes are accepted throughout. A put, a
// newline that does not scroll, a read and a no-op each pass through the idle
// and result states of the back end. A scrolling newline copies each window
// row but the bottom one up from the row below and then blanks the bottom row;
// a clear blanks every window row. The screen memory moves one cell per write,
// and a scroll spends a read and a write per cell. A two-entry command queue lets
// the host keep sending while the back end works, and a result register lets
// the next command start while a result waits to be taken.
// ----------------------------------------------------------------------------
module text_window_console #(
    parameter int ROWS = twc_pkg::ROWS_DEF,
    parameter int COLS = twc_pkg::COLS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    twc_in_if.sink                      i_in,
    twc_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [twc_pkg::APB_AW-1:0]  paddr,
    input  logic [twc_pkg::APB_DW-1:0]  pwdata,
    output logic [twc_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import twc_pkg::*;

    t_win_cfg cfg;
    t_cmd_rec push_rec;
    t_cmd_rec q_rec;
    logic     push;
    logic     q_full;
    logic     q_valid;
    logic     pop;
    logic     init_done;

    // Configuration registers
    twc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Accept and classify commands
    twc_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .i_init_done (init_done),
        .i_in        (i_in),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_rec       (push_rec)
    );

    // Decouple front and back
    twc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_rec   (q_rec)
    );

    // Execute on the screen memory
    twc_back #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_valid   (q_valid),
        .i_q_rec     (q_rec),
        .o_pop       (pop),
        .o_init_done (init_done),
        .o_out       (o_out)
    );

    // No command enters while the screen is being zeroed
    a_no_accept_in_init : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !init_done |-> !i_in.ready
    ) else $error("command accepted during screen clearing pass");

    // The clearing pass runs once per reset
    a_init_once : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !$fell(init_done)
    ) else $error("back end re-entered the clearing pass");

    // The back end only takes entries the queue holds
    a_pop_valid : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid
    ) else $error("queue popped while empty");

    // Reported cursor stays on the screen
    a_cursor_on_screen : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (32'(o_out.cursor_row) < ROWS && 32'(o_out.cursor_col) < COLS)
    ) else $error("cursor reported outside the screen");

endmodule

/* test/tb_text_window_console.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text window console testbench
// Sends put, clear, read and no-op commands under a series of output window
// settings. A cell-level model of the screen and cursor predicts every
// result, and each result transaction is checked in order against it. Both
// channel sides idle and stall at random. One long result stall backs up the
// command channel, and the command stream drains between phases.
// ----------------------------------------------------------------------------
module tb_text_window_console;
    import twc_pkg::*;

    localparam int ROWS         = ROWS_DEF;
    localparam int COLS         = COLS_DEF;
    localparam int CYCLE_LIMIT  = 10_000_000;
    localparam int HOLD_CYCLES  = 500;
    localparam int DRAIN_CYCLES = 16;
    localparam int NUM_PHASES   = 7;

    // Traffic shaping of the two channel sides
    typedef enum int {
        FLOW_FREE,
        FLOW_SEND_GAPS,
        FLOW_RECV_STALLS,
        FLOW_BOTH
    } t_flow;

    typedef struct packed {
        t_cmd              cmd;
        logic [CHAR_W-1:0] ch;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } t_console_cmd;

    typedef struct packed {
        logic [CHAR_W-1:0] cell_char;
        logic [ATTR_W-1:0] cell_attr;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
    } t_console_result;

    typedef struct {
        int    top;
        int    height;
        int    left;
        int    width;
        int    attr;
        int    items;
        t_flow flow;
        int    nl_pct;
        int    clr_pct;
    } t_phase;

    // Window settings of the random phases, extremes included
    t_phase phase_plan [NUM_PHASES] = '{
        '{2,  4,  5,   12,  'h1E, 300, FLOW_FREE,        8,  3},
        '{0,  1,  0,   1,   'hFF, 200, FLOW_SEND_GAPS,   8,  3},
        '{24, 25, 79,  80,  'h00, 150, FLOW_RECV_STALLS, 8,  3},
        '{31, 0,  127, 0,   'hA5, 100, FLOW_BOTH,        8,  3},
        '{20, 31, 70,  127, 'h5A, 300, FLOW_BOTH,        8,  3},
        '{0,  25, 0,   80,  'h70, 200, FLOW_SEND_GAPS,   10, 1},
        '{10, 6,  30,  25,  'h3C, 525, FLOW_RECV_STALLS, 8,  3}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    twc_in_if  cmd_if ();
    twc_out_if res_if ();

    // Channel drive registers, known from time zero
    logic         cmd_valid = 1'b0;
    t_console_cmd cmd_bus   = '0;
    logic         res_ready = 1'b0;

    assign cmd_if.valid     = cmd_valid;
    assign cmd_if.cmd       = cmd_bus.cmd;
    assign cmd_if.char_code = cmd_bus.ch;
    assign cmd_if.read_row  = cmd_bus.row;
    assign cmd_if.read_col  = cmd_bus.col;
    assign res_if.ready     = res_ready;

    text_window_console u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Console model state: screen, cursor and window registers
    logic [CHAR_W-1:0] scr_char [ROWS][COLS] = '{default: '0};
    logic [ATTR_W-1:0] scr_attr [ROWS][COLS] = '{default: '0};
    int                cur_row = 0;
    int                cur_col = 0;
    logic [ROW_W-1:0]  cfg_top    = TOP_RST;
    logic [ROW_W-1:0]  cfg_height = HEIGHT_RST;
    logic [COL_W-1:0]  cfg_left   = LEFT_RST;
    logic [COL_W-1:0]  cfg_width  = WIDTH_RST;
    logic [ATTR_W-1:0] cfg_attr   = ATTR_RST;

    t_console_cmd    pending_cmds [$];
    t_console_result expected_results [$];
    t_console_result predicted;
    int              cmds_queued   = 0;
    int              cmds_accepted = 0;
    int              err_cnt       = 0;
    int              cycle_cnt     = 0;
    int              hold_left     = 0;
    logic            hold_used;
    logic            hold_go;
    t_flow           flow;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int send_gap_pct(input t_flow f);
        case (f)
            FLOW_SEND_GAPS: return 80;
            FLOW_BOTH:      return 35;
            default:        return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct(input t_flow f);
        case (f)
            FLOW_RECV_STALLS: return 80;
            FLOW_BOTH:        return 35;
            default:          return 0;
        endcase
    endfunction

    // Clamp the window registers into screen bounds; bottom and right exclusive
    function automatic void window_box(output int wt, output int wb,
                                       output int wl, output int wr);
        int h;
        int w;
        wt = (cfg_top > ROWS - 1) ? ROWS - 1 : int'(cfg_top);
        wl = (cfg_left > COLS - 1) ? COLS - 1 : int'(cfg_left);
        h  = (cfg_height == 0) ? 1 : int'(cfg_height);
        w  = (cfg_width == 0) ? 1 : int'(cfg_width);
        wb = (wt + h > ROWS) ? ROWS : wt + h;
        wr = (wl + w > COLS) ? COLS : wl + w;
    endfunction

    task automatic blank_row(input int r, input int wl, input int wr);
        if (r < ROWS) begin
            for (int j = wl; j < wr; j++) begin
                scr_char[r][j] = CHAR_SPACE;
                scr_attr[r][j] = cfg_attr;
            end
        end
    endtask

    // Move to the next window row, scrolling the window when at its bottom
    task automatic advance_line(input int wt, input int wb, input int wl, input int wr);
        cur_col = wl;
        if (cur_row + 1 >= wb) begin
            cur_row = wb - 1;
            for (int i = wt; i < cur_row; i++) begin
                for (int j = wl; j < wr; j++) begin
                    scr_char[i][j] = scr_char[i + 1][j];
                    scr_attr[i][j] = scr_attr[i + 1][j];
                end
            end
            blank_row(cur_row, wl, wr);
        end else begin
            cur_row = cur_row + 1;
        end
    endtask

    // Apply one command to the console model and form its result
    task automatic console_step(input t_console_cmd c, output t_console_result r);
        int wt;
        int wb;
        int wl;
        int wr;
        window_box(wt, wb, wl, wr);
        r = '0;
        case (c.cmd)
            CMD_PUT: begin
                if (c.ch != CHAR_LF && c.ch != CHAR_CR) begin
                    if (cur_row < ROWS && cur_col < COLS) begin
                        scr_char[cur_row][cur_col] = c.ch;
                        scr_attr[cur_row][cur_col] = cfg_attr;
                    end
                    if (cur_col + 1 < wr) begin
                        cur_col = cur_col + 1;
                    end else begin
                        advance_line(wt, wb, wl, wr);
                    end
                end else begin
                    advance_line(wt, wb, wl, wr);
                end
            end
            CMD_CLEAR: begin
                for (int i = wt; i < wb; i++) begin
                    blank_row(i, wl, wr);
                end
                cur_row = wt;
                cur_col = wl;
            end
            CMD_READ: begin
                if (c.row < ROWS && c.col < COLS) begin
                    r.cell_char = scr_char[c.row][c.col];
                    r.cell_attr = scr_attr[c.row][c.col];
                end
            end
            default: begin
            end
        endcase
        r.cursor_row = ROW_W'(cur_row);
        r.cursor_col = COL_W'(cur_col);
    endtask

    // Command driver: predict each accepted transaction, then offer the next
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_valid <= 1'b0;
        end else begin
            if (cmd_valid && cmd_if.ready) begin
                console_step(cmd_bus, predicted);
                expected_results.push_back(predicted);
                cmds_accepted++;
            end
            if (!cmd_valid || cmd_if.ready) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_gap_pct(flow)) begin
                    cmd_bus   <= pending_cmds.pop_front();
                    cmd_valid <= 1'b1;
                end else begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(input string field, input logic [7:0] want,
                                   input logic [7:0] got);
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        err_cnt++;
    endtask

    task automatic check_result();
        t_console_result want;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, char %0h attr %0h row %0d col %0d", $time,
                     res_if.cell_char, res_if.cell_attr, res_if.cursor_row,
                     res_if.cursor_col);
            err_cnt++;
        end else begin
            want = expected_results.pop_front();
            if (res_if.cell_char !== want.cell_char)
                report_mismatch("cell_char", want.cell_char, res_if.cell_char);
            if (res_if.cell_attr !== want.cell_attr)
                report_mismatch("cell_attr", want.cell_attr, res_if.cell_attr);
            if (res_if.cursor_row !== want.cursor_row)
                report_mismatch("cursor_row", 8'(want.cursor_row), 8'(res_if.cursor_row));
            if (res_if.cursor_col !== want.cursor_col)
                report_mismatch("cursor_col", 8'(want.cursor_col), 8'(res_if.cursor_col));
        end
    endtask

    // Result monitor: check each transaction, stall at random or on hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ready <= 1'b0;
        end else begin
            if (res_if.valid && res_ready) begin
                check_result();
            end
            res_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct(flow));
        end
    end

    // Long result stall, armed once
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end else if (hold_go && !hold_used) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, expected_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic reg_write(input t_reg_idx idx, input int value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_WIN_TOP:    cfg_top    = ROW_W'(value);
            REG_WIN_HEIGHT: cfg_height = ROW_W'(value);
            REG_WIN_LEFT:   cfg_left   = COL_W'(value);
            REG_WIN_WIDTH:  cfg_width  = COL_W'(value);
            default:        cfg_attr   = ATTR_W'(value);
        endcase
    endtask

    task automatic set_window(input int top, input int height, input int left,
                              input int width, input int attr);
        reg_write(REG_WIN_TOP, top);
        reg_write(REG_WIN_HEIGHT, height);
        reg_write(REG_WIN_LEFT, left);
        reg_write(REG_WIN_WIDTH, width);
        reg_write(REG_TEXT_ATTR, attr);
    endtask

    // Hold until every queued command is taken and answered
    task automatic wait_drained();
        while (cmds_accepted != cmds_queued || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_cmd(input t_cmd op, input int ch, input int row, input int col);
        t_console_cmd c;
        c.cmd = op;
        c.ch  = CHAR_W'(ch);
        c.row = ROW_W'(row);
        c.col = COL_W'(col);
        pending_cmds.push_back(c);
        cmds_queued++;
    endtask

    // Random command; reads favor the window, the rest spans the whole field
    task automatic queue_random(input int nl_pct, input int clr_pct);
        int wt;
        int wb;
        int wl;
        int wr;
        int roll;
        int sel;
        int row;
        int col;
        window_box(wt, wb, wl, wr);
        roll = $urandom_range(99);
        row  = $urandom_range(31);
        col  = $urandom_range(127);
        if (roll < nl_pct) begin
            queue_cmd(CMD_PUT, $urandom_range(1) ? CHAR_LF : CHAR_CR, row, col);
        end else if (roll < nl_pct + clr_pct) begin
            queue_cmd(CMD_CLEAR, $urandom_range(255), row, col);
        end else if (roll < nl_pct + clr_pct + 3) begin
            queue_cmd(CMD_NOP, $urandom_range(255), row, col);
        end else if (roll < nl_pct + clr_pct + 25) begin
            sel = $urandom_range(9);
            if (sel < 6) begin
                row = wt + $urandom_range(wb - wt - 1);
                col = wl + $urandom_range(wr - wl - 1);
            end else if (sel < 8) begin
                row = $urandom_range(ROWS - 1);
                col = $urandom_range(COLS - 1);
            end
            queue_cmd(CMD_READ, $urandom_range(255), row, col);
        end else begin
            queue_cmd(CMD_PUT, $urandom_range(255), row, col);
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        hold_go <= 1'b0;
        flow    <= FLOW_FREE;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Full screen after reset: cleared store, reads off screen, no-op,
        // character extremes and both newline codes
        queue_cmd(CMD_READ, 0, 0, 0);
        queue_cmd(CMD_READ, 0, 24, 79);
        queue_cmd(CMD_READ, 0, 25, 0);
        queue_cmd(CMD_READ, 0, 0, 80);
        queue_cmd(CMD_READ, 'hFF, 31, 127);
        queue_cmd(CMD_NOP, 'hFF, 31, 127);
        queue_cmd(CMD_PUT, 'h41, 0, 0);
        queue_cmd(CMD_PUT, 'h00, 0, 0);
        queue_cmd(CMD_PUT, 'hFF, 0, 0);
        queue_cmd(CMD_READ, 0, 0, 2);
        queue_cmd(CMD_PUT, CHAR_LF, 0, 0);
        queue_cmd(CMD_PUT, CHAR_CR, 0, 0);
        queue_cmd(CMD_READ, 0, 0, 1);
        wait_drained();

        // Two-by-three window: wrap at the right edge, scroll on wrap and on newline
        set_window(3, 2, 10, 3, 'hC3);
        queue_cmd(CMD_CLEAR, 0, 0, 0);
        queue_cmd(CMD_PUT, "a", 0, 0);
        queue_cmd(CMD_PUT, "b", 0, 0);
        queue_cmd(CMD_PUT, "c", 0, 0);
        queue_cmd(CMD_PUT, "d", 0, 0);
        queue_cmd(CMD_PUT, "e", 0, 0);
        queue_cmd(CMD_PUT, "f", 0, 0);
        queue_cmd(CMD_READ, 0, 3, 10);
        queue_cmd(CMD_READ, 0, 4, 12);
        queue_cmd(CMD_PUT, CHAR_CR, 0, 0);
        queue_cmd(CMD_READ, 0, 3, 11);
        queue_cmd(CMD_READ, 0, 9, 9);

        // Random phases, each started from a drained block
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            set_window(phase_plan[p].top, phase_plan[p].height, phase_plan[p].left,
                       phase_plan[p].width, phase_plan[p].attr);
            flow <= phase_plan[p].flow;
            if (p == 0) begin
                hold_go <= 1'b1;
            end
            for (int k = 0; k < phase_plan[p].items; k++) begin
                queue_random(phase_plan[p].nl_pct, phase_plan[p].clr_pct);
            end
        end
        wait_drained();

        if (err_cnt == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/twc_pkg.sv
hw/rtl/twc_if.sv
hw/rtl/twc_regs.sv
hw/rtl/twc_front.sv
hw/rtl/twc_queue.sv
hw/rtl/twc_back.sv
hw/rtl/text_window_console.sv
test/tb_text_window_console.sv
